// ===== src/bfd_pkg.sv =====
// box filter downsampler package: sizes, register indexes and shared types
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps

package bfd_pkg;

	localparam int MAX_OUT_WIDTH = 1024;
	localparam int MAX_RATIO     = 16;
	localparam int CHANNEL_BITS  = 8;
	localparam int NUM_LANES     = 4;

	// fixed by the register and field formats
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;
	localparam int IW_W       = 13;
	localparam int RATIO_CFG_W = 5;
	localparam int DIM_W      = 11;
	localparam int COLP_W     = 12;
	localparam int POS_W      = 13;
	localparam int OUT_POS_W  = 10;

	// derived from the parameters
	localparam int COL_W   = $clog2(MAX_OUT_WIDTH);
	localparam int BCOL_W  = $clog2(MAX_OUT_WIDTH + 1);
	localparam int RIB_W   = $clog2(MAX_RATIO);
	localparam int RATIO_W = $clog2(MAX_RATIO + 1);
	localparam int AREA_W  = $clog2(MAX_RATIO * MAX_RATIO + 1);
	localparam int SUM_W   = $clog2(((1 << CHANNEL_BITS) - 1) * MAX_RATIO * MAX_RATIO + 1);
	localparam int CNT_W   = $clog2(CHANNEL_BITS);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RATIO_X    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RATIO_Y    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = 3'd4;

	typedef logic [CHANNEL_BITS-1:0] bfd_pix_t;
	typedef logic [SUM_W-1:0] bfd_sum_t;

	typedef struct packed {
		logic load;
		logic step;
	} bfd_lane_ctrl_t;

	typedef struct packed {
		logic [OUT_POS_W-1:0] col;
		logic [OUT_POS_W-1:0] row;
	} bfd_tag_t;

endpackage

// ===== src/bfd_div_lane.sv =====
// one channel lane: restoring divider of a block sum by the block area,
// one quotient bit per cycle while ctrl.step is set; depends on bfd_pkg
`timescale 1ns / 1ps

module bfd_div_lane (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bfd_pkg::bfd_lane_ctrl_t      ctrl,
	input  bfd_pkg::bfd_sum_t            sum,
	input  logic [bfd_pkg::AREA_W-1:0]   area,
	output bfd_pkg::bfd_pix_t            quot
);

	bfd_pkg::bfd_sum_t rem_q;
	bfd_pkg::bfd_sum_t div_q;
	bfd_pkg::bfd_pix_t quot_q;
	logic              ge;

	assign ge   = rem_q >= div_q;
	assign quot = quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			div_q  <= '0;
			quot_q <= '0;
		end else if (ctrl.load) begin
			rem_q  <= sum;
			div_q  <= bfd_pkg::SUM_W'(area) << (bfd_pkg::CHANNEL_BITS - 1);
			quot_q <= '0;
		end else if (ctrl.step) begin
			if (ge) begin
				rem_q <= rem_q - div_q;
			end
			div_q  <= div_q >> 1;
			quot_q <= {quot_q[bfd_pkg::CHANNEL_BITS-2:0], ge};
		end
	end

endmodule

// ===== src/bfd_merge.sv =====
// merging stage: collects the lane quotients and block position into the
// output register; depends on bfd_pkg
`timescale 1ns / 1ps

module bfd_merge (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  bfd_pkg::bfd_tag_t   tag,
	input  bfd_pkg::bfd_pix_t   quot [bfd_pkg::NUM_LANES],
	input  logic                out_ready,
	output logic                out_valid,
	output logic                free,
	output bfd_pkg::bfd_pix_t   ch [bfd_pkg::NUM_LANES],
	output bfd_pkg::bfd_tag_t   tag_out
);

	logic              valid_q;
	bfd_pkg::bfd_pix_t ch_q [bfd_pkg::NUM_LANES];
	bfd_pkg::bfd_tag_t tag_q;

	assign out_valid = valid_q;
	assign free      = !valid_q || out_ready;
	assign ch        = ch_q;
	assign tag_out   = tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ch_q  <= quot;
			tag_q <= tag;
		end
	end

endmodule

// ===== src/box_filter_downsampler_top.sv =====
// box filter downsampler top level: configuration registers, position
// counters, block sum memory and control; uses bfd_pkg, bfd_div_lane, bfd_merge
`timescale 1ns / 1ps

// usage
//   input channel: in_valid/in_ready with frame_start and in_ch0..in_ch3, one
//   pixel per item in raster order; frame_start restarts the position counters
//   output channel: out_valid/out_ready with out_ch0..out_ch3, out_col, out_row,
//   one item per finished ratio_x by ratio_y block, on its bottom-right pixel
//   config channel: cfg_valid/cfg_ready with cfg_index and cfg_data, always
//   ready; write only while no item is in flight
// processing steps
//   a pixel that closes no block: memory read, sum write back
//   a pixel that closes a block: read, write back, division in the four divider
//   lanes (one quotient bit per cycle), hand-off to the output register once it
//   is free; out_valid is registered from the hand-off
//   a new pixel is taken only once the last one's steps are done
// reset
//   counters clear, registers return to 1024, 2, 2, 512, 384; the sum memory
//   is not cleared, each block writes its sums on its top-left pixel
// stalls
//   the next pixel is taken while a result waits in the output register; a
//   new result waits in the lanes until the output register is free

module box_filter_downsampler_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bfd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bfd_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               frame_start,
	input  logic [7:0]                         in_ch0,
	input  logic [7:0]                         in_ch1,
	input  logic [7:0]                         in_ch2,
	input  logic [7:0]                         in_ch3,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [7:0]                         out_ch0,
	output logic [7:0]                         out_ch1,
	output logic [7:0]                         out_ch2,
	output logic [7:0]                         out_ch3,
	output logic [bfd_pkg::OUT_POS_W-1:0]      out_col,
	output logic [bfd_pkg::OUT_POS_W-1:0]      out_row
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_UPD,
		S_DIV,
		S_DONE
	} state_t;

	state_t state_q;

	// configuration registers
	logic [bfd_pkg::IW_W-1:0]        in_width_q;
	logic [bfd_pkg::RATIO_CFG_W-1:0] ratio_x_q;
	logic [bfd_pkg::RATIO_CFG_W-1:0] ratio_y_q;
	logic [bfd_pkg::DIM_W-1:0]       out_width_q;
	logic [bfd_pkg::DIM_W-1:0]       out_height_q;

	// effective (clamped) settings
	logic [bfd_pkg::IW_W-1:0]        iw_eff;
	logic [bfd_pkg::RATIO_CFG_W-1:0] rx_c;
	logic [bfd_pkg::RATIO_CFG_W-1:0] ry_c;
	logic [bfd_pkg::RATIO_W-1:0]     rx_eff;
	logic [bfd_pkg::RATIO_W-1:0]     ry_eff;
	logic [bfd_pkg::DIM_W-1:0]       ow_c;
	logic [bfd_pkg::POS_W-1:0]       ow_eff;
	logic [bfd_pkg::DIM_W-1:0]       oh_eff;
	logic [bfd_pkg::AREA_W-1:0]      area;

	// position counters
	logic [bfd_pkg::COLP_W-1:0]  column_pos_q;
	logic [bfd_pkg::RIB_W-1:0]   column_in_block_q;
	logic [bfd_pkg::BCOL_W-1:0]  block_column_q;
	logic [bfd_pkg::RIB_W-1:0]   row_in_block_q;
	logic [bfd_pkg::DIM_W-1:0]   block_row_q;

	logic [bfd_pkg::COLP_W-1:0]  cp_c, cp_n;
	logic [bfd_pkg::RIB_W-1:0]   cib_c, cib_n;
	logic [bfd_pkg::BCOL_W-1:0]  bc_c, bc_n;
	logic [bfd_pkg::RIB_W-1:0]   rib_c, rib_n;
	logic [bfd_pkg::DIM_W-1:0]   br_c, br_n;
	logic                        last_col, last_row, covered, first, emit;

	// first stage
	bfd_pkg::bfd_pix_t           px_s1 [bfd_pkg::NUM_LANES];
	logic [bfd_pkg::BCOL_W-1:0]  bc_s1;
	logic [bfd_pkg::DIM_W-1:0]   br_s1;
	logic                        first_s1;
	logic                        covered_s1;
	logic                        emit_s1;

	// column sum memory
	logic [bfd_pkg::NUM_LANES*bfd_pkg::SUM_W-1:0] sums_mem [bfd_pkg::MAX_OUT_WIDTH];
	logic [bfd_pkg::NUM_LANES*bfd_pkg::SUM_W-1:0] rd_q;
	logic [bfd_pkg::NUM_LANES*bfd_pkg::SUM_W-1:0] wr_data;
	bfd_pkg::bfd_sum_t           new_sum [bfd_pkg::NUM_LANES];
	bfd_pkg::bfd_pix_t           px_in [bfd_pkg::NUM_LANES];

	// divider and output
	logic [bfd_pkg::CNT_W-1:0]   div_cnt_q;
	bfd_pkg::bfd_lane_ctrl_t     lane_ctrl;
	bfd_pkg::bfd_pix_t           quot [bfd_pkg::NUM_LANES];
	bfd_pkg::bfd_tag_t           tag_q;
	bfd_pkg::bfd_tag_t           tag_out;
	bfd_pkg::bfd_pix_t           ch_out [bfd_pkg::NUM_LANES];
	logic                        mrg_load;
	logic                        mrg_free;
	logic                        in_fire;

	assign cfg_ready = 1'b1;
	assign in_ready  = state_q == S_IDLE;
	assign in_fire   = in_valid && in_ready;

	assign px_in[0] = in_ch0;
	assign px_in[1] = in_ch1;
	assign px_in[2] = in_ch2;
	assign px_in[3] = in_ch3;

	// register clamping
	always_comb begin
		if (in_width_q == '0) begin
			iw_eff = bfd_pkg::IW_W'(1);
		end else if (in_width_q > bfd_pkg::IW_W'(4096)) begin
			iw_eff = bfd_pkg::IW_W'(4096);
		end else begin
			iw_eff = in_width_q;
		end

		if (ratio_x_q == '0) begin
			rx_c = bfd_pkg::RATIO_CFG_W'(1);
		end else if (ratio_x_q > bfd_pkg::RATIO_CFG_W'(16)) begin
			rx_c = bfd_pkg::RATIO_CFG_W'(16);
		end else begin
			rx_c = ratio_x_q;
		end
		if (32'(rx_c) > 32'(bfd_pkg::MAX_RATIO)) begin
			rx_eff = bfd_pkg::RATIO_W'(bfd_pkg::MAX_RATIO);
		end else begin
			rx_eff = bfd_pkg::RATIO_W'(rx_c);
		end

		if (ratio_y_q == '0) begin
			ry_c = bfd_pkg::RATIO_CFG_W'(1);
		end else if (ratio_y_q > bfd_pkg::RATIO_CFG_W'(16)) begin
			ry_c = bfd_pkg::RATIO_CFG_W'(16);
		end else begin
			ry_c = ratio_y_q;
		end
		if (32'(ry_c) > 32'(bfd_pkg::MAX_RATIO)) begin
			ry_eff = bfd_pkg::RATIO_W'(bfd_pkg::MAX_RATIO);
		end else begin
			ry_eff = bfd_pkg::RATIO_W'(ry_c);
		end

		if (out_width_q == '0) begin
			ow_c = bfd_pkg::DIM_W'(1);
		end else if (out_width_q > bfd_pkg::DIM_W'(1024)) begin
			ow_c = bfd_pkg::DIM_W'(1024);
		end else begin
			ow_c = out_width_q;
		end
		if (32'(ow_c) > 32'(bfd_pkg::MAX_OUT_WIDTH)) begin
			ow_eff = bfd_pkg::POS_W'(bfd_pkg::MAX_OUT_WIDTH);
		end else begin
			ow_eff = bfd_pkg::POS_W'(ow_c);
		end

		if (out_height_q == '0) begin
			oh_eff = bfd_pkg::DIM_W'(1);
		end else if (out_height_q > bfd_pkg::DIM_W'(1024)) begin
			oh_eff = bfd_pkg::DIM_W'(1024);
		end else begin
			oh_eff = out_height_q;
		end

		area = bfd_pkg::AREA_W'(rx_eff * ry_eff);
	end

	// position of the incoming pixel and where the counters go next
	always_comb begin
		cp_c  = frame_start ? '0 : column_pos_q;
		cib_c = frame_start ? '0 : column_in_block_q;
		bc_c  = frame_start ? '0 : block_column_q;
		rib_c = frame_start ? '0 : row_in_block_q;
		br_c  = frame_start ? '0 : block_row_q;

		last_col = bfd_pkg::RATIO_W'(cib_c) + bfd_pkg::RATIO_W'(1) >= rx_eff;
		last_row = bfd_pkg::RATIO_W'(rib_c) + bfd_pkg::RATIO_W'(1) >= ry_eff;
		covered  = (br_c < oh_eff) && (bfd_pkg::POS_W'(bc_c) < ow_eff);
		first    = (cib_c == '0) && (rib_c == '0);
		emit     = covered && last_col && last_row;

		cp_n  = cp_c;
		cib_n = cib_c;
		bc_n  = bc_c;
		rib_n = rib_c;
		br_n  = br_c;
		if (bfd_pkg::POS_W'(cp_c) + bfd_pkg::POS_W'(1) >= bfd_pkg::POS_W'(iw_eff)) begin
			cp_n  = '0;
			cib_n = '0;
			bc_n  = '0;
			if (last_row) begin
				rib_n = '0;
				if (br_c < oh_eff) begin
					br_n = br_c + bfd_pkg::DIM_W'(1);
				end
			end else begin
				rib_n = rib_c + bfd_pkg::RIB_W'(1);
			end
		end else begin
			cp_n = cp_c + bfd_pkg::COLP_W'(1);
			if (last_col) begin
				cib_n = '0;
				if (bfd_pkg::POS_W'(bc_c) < ow_eff) begin
					bc_n = bc_c + bfd_pkg::BCOL_W'(1);
				end
			end else begin
				cib_n = cib_c + bfd_pkg::RIB_W'(1);
			end
		end
	end

	// new channel sums of the block
	always_comb begin
		for (int c = 0; c < bfd_pkg::NUM_LANES; c++) begin
			if (first_s1) begin
				new_sum[c] = bfd_pkg::SUM_W'(px_s1[c]);
			end else begin
				new_sum[c] = rd_q[c*bfd_pkg::SUM_W +: bfd_pkg::SUM_W]
					+ bfd_pkg::SUM_W'(px_s1[c]);
			end
			wr_data[c*bfd_pkg::SUM_W +: bfd_pkg::SUM_W] = new_sum[c];
		end
	end

	assign lane_ctrl.load = (state_q == S_UPD) && emit_s1;
	assign lane_ctrl.step = state_q == S_DIV;
	assign mrg_load       = (state_q == S_DONE) && mrg_free;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_width_q   <= bfd_pkg::IW_W'(1024);
			ratio_x_q    <= bfd_pkg::RATIO_CFG_W'(2);
			ratio_y_q    <= bfd_pkg::RATIO_CFG_W'(2);
			out_width_q  <= bfd_pkg::DIM_W'(512);
			out_height_q <= bfd_pkg::DIM_W'(384);
		end else if (cfg_valid) begin
			case (cfg_index)
				bfd_pkg::REG_IN_WIDTH:   in_width_q   <= cfg_data[bfd_pkg::IW_W-1:0];
				bfd_pkg::REG_RATIO_X:    ratio_x_q    <= cfg_data[bfd_pkg::RATIO_CFG_W-1:0];
				bfd_pkg::REG_RATIO_Y:    ratio_y_q    <= cfg_data[bfd_pkg::RATIO_CFG_W-1:0];
				bfd_pkg::REG_OUT_WIDTH:  out_width_q  <= cfg_data[bfd_pkg::DIM_W-1:0];
				bfd_pkg::REG_OUT_HEIGHT: out_height_q <= cfg_data[bfd_pkg::DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// control state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= S_IDLE;
			column_pos_q      <= '0;
			column_in_block_q <= '0;
			block_column_q    <= '0;
			row_in_block_q    <= '0;
			block_row_q       <= '0;
			first_s1          <= 1'b0;
			covered_s1        <= 1'b0;
			emit_s1           <= 1'b0;
			div_cnt_q         <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						column_pos_q      <= cp_n;
						column_in_block_q <= cib_n;
						block_column_q    <= bc_n;
						row_in_block_q    <= rib_n;
						block_row_q       <= br_n;
						first_s1          <= first;
						covered_s1        <= covered;
						emit_s1           <= emit;
						state_q           <= S_UPD;
					end
				end
				S_UPD: begin
					div_cnt_q <= '0;
					state_q   <= emit_s1 ? S_DIV : S_IDLE;
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + bfd_pkg::CNT_W'(1);
					if (div_cnt_q == bfd_pkg::CNT_W'(bfd_pkg::CHANNEL_BITS - 1)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (mrg_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item payload and block position
	always_ff @(posedge clk) begin
		if (in_fire) begin
			px_s1 <= px_in;
			bc_s1 <= bc_c;
			br_s1 <= br_c;
		end
		if (lane_ctrl.load) begin
			tag_q.col <= bc_s1[bfd_pkg::OUT_POS_W-1:0];
			tag_q.row <= br_s1[bfd_pkg::OUT_POS_W-1:0];
		end
	end

	// column sum memory, read on accept, written back in the following cycle for a covered pixel
	always_ff @(posedge clk) begin
		if (in_fire) begin
			rd_q <= sums_mem[bc_c[bfd_pkg::COL_W-1:0]];
		end
		if ((state_q == S_UPD) && covered_s1) begin
			sums_mem[bc_s1[bfd_pkg::COL_W-1:0]] <= wr_data;
		end
	end

	for (genvar g = 0; g < bfd_pkg::NUM_LANES; g++) begin : g_lane
		bfd_div_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (lane_ctrl),
			.sum    (new_sum[g]),
			.area   (area),
			.quot   (quot[g])
		);
	end

	bfd_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (mrg_load),
		.tag       (tag_q),
		.quot      (quot),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.free      (mrg_free),
		.ch        (ch_out),
		.tag_out   (tag_out)
	);

	assign out_ch0 = ch_out[0];
	assign out_ch1 = ch_out[1];
	assign out_ch2 = ch_out[2];
	assign out_ch3 = ch_out[3];
	assign out_col = tag_out.col;
	assign out_row = tag_out.row;

	a_busy_after_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted in back-to-back cycles");

	a_load_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		mrg_load |-> (!out_valid || out_ready))
		else $error("output register overwritten while stalled");

	a_no_result_returns: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD) && !emit_s1 |=> in_ready)
		else $error("item without result did not release input");

	a_div_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) && (div_cnt_q == bfd_pkg::CNT_W'(bfd_pkg::CHANNEL_BITS - 1))
		|=> state_q == S_DONE)
		else $error("divider did not finish after all quotient bits");

endmodule

// ===== bench/box_filter_downsampler_top_tb.sv =====
// testbench for box_filter_downsampler_top: random and directed pixel streams
// checked against a block-average predictor; uses bfd_pkg and the block's RTL
`timescale 1ns / 1ps

module box_filter_downsampler_top_tb;
	import bfd_pkg::*;

	localparam int QUIET_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 16;
	localparam int MAX_REPORTS   = 40;
	localparam int RATIO_CAP     = (MAX_RATIO < 16) ? MAX_RATIO : 16;
	localparam int OUT_WIDTH_CAP = (MAX_OUT_WIDTH < 1024) ? MAX_OUT_WIDTH : 1024;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic                                frame_start;
		logic [NUM_LANES-1:0][CHANNEL_BITS-1:0] ch;
	} pixel_t;

	typedef struct packed {
		logic [NUM_LANES-1:0][CHANNEL_BITS-1:0] ch;
		logic [OUT_POS_W-1:0]                 col;
		logic [OUT_POS_W-1:0]                 row;
	} block_avg_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic frame_start = 1'b0;
	logic [7:0] in_ch0 = '0;
	logic [7:0] in_ch1 = '0;
	logic [7:0] in_ch2 = '0;
	logic [7:0] in_ch3 = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] out_ch0;
	logic [7:0] out_ch1;
	logic [7:0] out_ch2;
	logic [7:0] out_ch3;
	logic [OUT_POS_W-1:0] out_col;
	logic [OUT_POS_W-1:0] out_row;

	// predictor state
	logic [IW_W-1:0]        reg_in_width = 13'd1024;
	logic [RATIO_CFG_W-1:0] reg_ratio_x = 5'd2;
	logic [RATIO_CFG_W-1:0] reg_ratio_y = 5'd2;
	logic [DIM_W-1:0]       reg_out_width = 11'd512;
	logic [DIM_W-1:0]       reg_out_height = 11'd384;
	int unsigned column_sums [MAX_OUT_WIDTH][NUM_LANES];
	int column_pos = 0;
	int column_in_block = 0;
	int block_column = 0;
	int row_in_block = 0;
	int block_row = 0;

	block_avg_t expected_blocks[$];
	int error_count = 0;
	int quiet_cycles = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int recv_hold = 0;

	box_filter_downsampler_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.frame_start(frame_start),
		.in_ch0     (in_ch0),
		.in_ch1     (in_ch1),
		.in_ch2     (in_ch2),
		.in_ch3     (in_ch3),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_ch0    (out_ch0),
		.out_ch1    (out_ch1),
		.out_ch2    (out_ch2),
		.out_ch3    (out_ch3),
		.out_col    (out_col),
		.out_row    (out_row)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int clamp_to(input int v, input int lo, input int hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic pixel_t make_pixel(input logic fs, input logic [7:0] c0,
			input logic [7:0] c1, input logic [7:0] c2, input logic [7:0] c3);
		pixel_t p;
		p.frame_start = fs;
		p.ch = {c3, c2, c1, c0};
		return p;
	endfunction

	// sums one pixel into its block and queues the average when the block closes
	task automatic accumulate_pixel(input pixel_t p);
		int iw, rx, ry, ow, oh, area, c;
		logic last_col, last_row;
		block_avg_t avg;
		iw = clamp_to(reg_in_width, 1, 4096);
		rx = clamp_to(reg_ratio_x, 1, RATIO_CAP);
		ry = clamp_to(reg_ratio_y, 1, RATIO_CAP);
		ow = clamp_to(reg_out_width, 1, OUT_WIDTH_CAP);
		oh = clamp_to(reg_out_height, 1, 1024);
		if (p.frame_start) begin
			column_pos = 0;
			column_in_block = 0;
			block_column = 0;
			row_in_block = 0;
			block_row = 0;
		end
		last_col = (column_in_block + 1 >= rx);
		last_row = (row_in_block + 1 >= ry);
		if (block_row < oh && block_column < ow) begin
			for (c = 0; c < NUM_LANES; c++) begin
				if (column_in_block == 0 && row_in_block == 0)
					column_sums[block_column][c] = p.ch[c];
				else
					column_sums[block_column][c] += p.ch[c];
			end
			if (last_col && last_row) begin
				area = rx * ry;
				for (c = 0; c < NUM_LANES; c++)
					avg.ch[c] = CHANNEL_BITS'(column_sums[block_column][c] / area);
				avg.col = OUT_POS_W'(block_column);
				avg.row = OUT_POS_W'(block_row);
				expected_blocks.push_back(avg);
			end
		end
		if (column_pos + 1 >= iw) begin
			column_pos = 0;
			column_in_block = 0;
			block_column = 0;
			if (last_row) begin
				row_in_block = 0;
				if (block_row < oh)
					block_row++;
			end else begin
				row_in_block++;
			end
		end else begin
			column_pos++;
			if (last_col) begin
				column_in_block = 0;
				if (block_column < ow)
					block_column++;
			end else begin
				column_in_block++;
			end
		end
	endtask

	task automatic send_pixel(input pixel_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		frame_start <= p.frame_start;
		in_ch0 <= p.ch[0];
		in_ch1 <= p.ch[1];
		in_ch2 <= p.ch[2];
		in_ch3 <= p.ch[3];
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		accumulate_pixel(p);
	endtask

	// first item opens a frame, later ones restart it now and then
	task automatic send_pixels(input int count, input int restart_pct);
		pixel_t p;
		int i, c;
		for (i = 0; i < count; i++) begin
			for (c = 0; c < NUM_LANES; c++) begin
				case ($urandom_range(9))
					0: p.ch[c] = 8'hFF;
					1: p.ch[c] = 8'h00;
					default: p.ch[c] = 8'($urandom_range(255));
				endcase
			end
			p.frame_start = (i == 0) || ($urandom_range(99) < restart_pct);
			send_pixel(p);
		end
	endtask

	task automatic quiesce_input();
		in_valid <= 1'b0;
		while (expected_blocks.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_IN_WIDTH:   reg_in_width = data[IW_W-1:0];
			REG_RATIO_X:    reg_ratio_x = data[RATIO_CFG_W-1:0];
			REG_RATIO_Y:    reg_ratio_y = data[RATIO_CFG_W-1:0];
			REG_OUT_WIDTH:  reg_out_width = data[DIM_W-1:0];
			REG_OUT_HEIGHT: reg_out_height = data[DIM_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input int iw, input int rx, input int ry, input int ow, input int oh);
		quiesce_input();
		write_reg(REG_IN_WIDTH, CFG_DATA_W'(iw));
		write_reg(REG_RATIO_X, CFG_DATA_W'(rx));
		write_reg(REG_RATIO_Y, CFG_DATA_W'(ry));
		write_reg(REG_OUT_WIDTH, CFG_DATA_W'(ow));
		write_reg(REG_OUT_HEIGHT, CFG_DATA_W'(oh));
		cfg_valid <= 1'b0;
	endtask

	task automatic report_mismatch(input string field, input logic [9:0] want, input logic [9:0] got);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
	endtask

	// reset values: one full 1024-pixel row, then the first two blocks of row pair 0
	task automatic test_reset_defaults();
		send_pixels(1024 + 4, 0);
	endtask

	task automatic test_directed_blocks();
		set_config(4, 2, 2, 2, 1);
		send_pixel(make_pixel(1'b1, 8'hFF, 8'h00, 8'h80, 8'h01));
		send_pixel(make_pixel(1'b0, 8'hFF, 8'h00, 8'h80, 8'h01));
		send_pixel(make_pixel(1'b0, 8'h03, 8'hFF, 8'h00, 8'h01));
		send_pixel(make_pixel(1'b0, 8'h02, 8'hFF, 8'h00, 8'h01));
		send_pixel(make_pixel(1'b0, 8'hFF, 8'h00, 8'h80, 8'h01));
		send_pixel(make_pixel(1'b0, 8'hFF, 8'h00, 8'h80, 8'h01));
		send_pixel(make_pixel(1'b0, 8'h02, 8'hFF, 8'h00, 8'h01));
		send_pixel(make_pixel(1'b0, 8'h02, 8'hFE, 8'h00, 8'h00));
		// rows below the last block row are ignored
		send_pixel(make_pixel(1'b0, 8'h55, 8'hAA, 8'h55, 8'hAA));
		send_pixel(make_pixel(1'b0, 8'hAA, 8'h55, 8'hAA, 8'h55));
		// frame restart in the middle of a row
		send_pixels(8, 0);
	endtask

	task automatic test_register_clamping();
		set_config(0, 0, 0, 0, 0);
		write_reg(REG_UNUSED, 13'h1FFF);
		cfg_valid <= 1'b0;
		send_pixel(make_pixel(1'b1, 8'h12, 8'h34, 8'h56, 8'h78));
		send_pixel(make_pixel(1'b0, 8'h9A, 8'hBC, 8'hDE, 8'hF0));
		send_pixel(make_pixel(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		send_pixel(make_pixel(1'b0, 8'h00, 8'h00, 8'h00, 8'h00));
		set_config(8191, 31, 0, 2047, 2047);
		send_pixels(32, 0);
		set_config(16, 16, 31, 1, 1);
		send_pixels(256 + 16, 0);
	endtask

	// blocks cut short by the row end, and columns past the last block
	task automatic test_row_end_cases();
		set_config(7, 2, 2, 4, 2);
		send_pixels(7 * 4 + 7, 0);
		send_pixels(7 * 4, 0);
		set_config(9, 2, 2, 2, 2);
		send_pixels(9 * 4 + 9, 0);
	endtask

	task automatic test_full_output_width();
		set_config(1024, 1, 1, 1024, 1);
		send_pixels(1024 + 8, 0);
	endtask

	task automatic test_output_backpressure();
		int saved_send;
		saved_send = send_idle_pct;
		send_idle_pct = 0;
		set_config(4, 1, 1, 4, 1024);
		recv_hold = 300;
		send_pixels(60, 0);
		quiesce_input();
		send_pixels(20, 0);
		send_idle_pct = saved_send;
	endtask

	task automatic test_random_frames(input int item_budget);
		int sent, iw, rx, ry, ow, oh, frame_len, n;
		sent = 0;
		while (sent < item_budget) begin
			rx = $urandom_range(1, 4);
			ry = $urandom_range(1, 3);
			iw = $urandom_range(1, 12);
			if ($urandom_range(7) == 0) begin
				rx = $urandom_range(5, 16);
				iw = $urandom_range(rx, 3 * rx);
				ry = 1;
			end
			ow = $urandom_range(1, iw / rx + 1);
			oh = $urandom_range(1, 3);
			set_config(iw, rx, ry, ow, oh);
			repeat ($urandom_range(1, 3)) begin
				frame_len = iw * ry * oh;
				if ($urandom_range(3) == 0) begin
					n = $urandom_range(1, frame_len + iw);
					send_pixels(n, 8);
				end else begin
					n = frame_len + iw * $urandom_range(0, 1);
					send_pixels(n, 0);
				end
				sent += n;
			end
		end
	endtask

	always @(posedge clk) begin : result_check
		block_avg_t got, want;
		int c;
		if (out_valid && out_ready) begin
			got.ch = {out_ch3, out_ch2, out_ch1, out_ch0};
			got.col = out_col;
			got.row = out_row;
			if (expected_blocks.size() == 0) begin
				error_count++;
				if (error_count <= MAX_REPORTS)
					$display("%0t: unexpected item, col %0d row %0d", $time, out_col, out_row);
			end else begin
				want = expected_blocks.pop_front();
				for (c = 0; c < NUM_LANES; c++)
					if (got.ch[c] !== want.ch[c])
						report_mismatch($sformatf("out_ch%0d", c), want.ch[c], got.ch[c]);
				if (got.col !== want.col)
					report_mismatch("out_col", want.col, got.col);
				if (got.row !== want.row)
					report_mismatch("out_row", want.row, got.row);
			end
		end
		if (recv_hold > 0) begin
			recv_hold--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 31;
		recv_idle_pct = 46;
		test_reset_defaults();
		test_directed_blocks();
		test_register_clamping();
		test_random_frames(200);

		send_idle_pct = 46;
		recv_idle_pct = 31;
		test_row_end_cases();
		test_random_frames(200);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_full_output_width();
		test_output_backpressure();
		test_random_frames(200);

		quiesce_input();
		if (error_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
